// ----- rtl/ftfd_pkg.sv -----
// Shared types, codes and decode helpers for the FP trap fixup decider.
// No dependencies; imported by the decode, tally and top-level modules.
`default_nettype none
package ftfd_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned RegWidth   = 5;
   localparam int unsigned NumClasses = 7;

   typedef enum logic [2:0] {
      CLS_INEXACT   = 3'd0,
      CLS_UNDERFLOW = 3'd1,
      CLS_OVERFLOW  = 3'd2,
      CLS_DIVZERO   = 3'd3,
      CLS_INVALID   = 3'd4,
      CLS_UNIMPL    = 3'd5,
      CLS_NONE      = 3'd6
   } class_type;

   typedef enum logic [1:0] {
      VERDICT_FIXED     = 2'd0,
      VERDICT_NOT_EMUL  = 2'd1,
      VERDICT_BAD_JUMP  = 2'd2,
      VERDICT_NO_SKIP   = 2'd3
   } verdict_type;

   localparam logic [5:0] OPC_SPECIAL = 6'd0;
   localparam logic [5:0] OPC_J       = 6'd2;
   localparam logic [5:0] OPC_JAL     = 6'd3;
   localparam logic [5:0] OPC_COP1    = 6'd17;
   localparam logic [5:0] FN_JR       = 6'd8;
   localparam logic [5:0] FN_JALR     = 6'd9;

   localparam logic [4:0] FMT_S = 5'd16;
   localparam logic [4:0] FMT_D = 5'd17;
   localparam logic [4:0] FMT_W = 5'd20;

   localparam logic [5:0] FN_ABS = 6'd5;
   localparam logic [5:0] FN_CVT_S = 6'd32;
   localparam logic [5:0] FN_CVT_W = 6'd36;

   localparam logic [4:0] LINK_REG = 5'd31;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_TWO   = 2'd2,
      KIND_THREE = 2'd3
   } kind_type;

   typedef struct packed {
      class_type               exc_class;
      verdict_type             verdict;
      logic [WordWidth-1:0]    resume_pc;
      logic [WordWidth-1:0]    cleared_status;
      logic                    zero_dest_enable;
      logic [RegWidth-1:0]     zero_dest_index;
      logic                    link_enable;
      logic [RegWidth-1:0]     link_index;
      logic [WordWidth-1:0]    link_value;
   } result_type;

   function automatic logic float_ok(input logic [31:0] v);
      logic [7:0]  e;
      logic [22:0] m;
      logic        ok;
      e = v[30:23];
      m = v[22:0];
      if (e == 8'h00) ok = (m == 23'd0);
      else            ok = (e != 8'hFF);
      return ok;
   endfunction

   function automatic kind_type op_kind(input logic [4:0] fmt, input logic [5:0] fn);
      kind_type k;
      k = KIND_NONE;
      if (fmt == FMT_S && fn <= 6'd3)          k = KIND_THREE;
      else if (fmt == FMT_S && fn == FN_ABS)   k = KIND_TWO;
      else if (fmt == FMT_D && fn == FN_CVT_S) k = KIND_TWO;
      else if (fmt == FMT_W && fn == FN_CVT_S) k = KIND_TWO;
      else if (fmt == FMT_S && fn == FN_CVT_W) k = KIND_TWO;
      return k;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/ftfd_decode.sv -----
// Combinational trap decode: cause selection, delay-slot jump emulation and
// FP instruction check. Depends on ftfd_pkg.
`default_nettype none
module ftfd_decode
   import ftfd_pkg::*;
(
   input  wire logic [31:0] fp_status_word,
   input  wire logic        in_delay_slot,
   input  wire logic [31:0] trap_pc,
   input  wire logic [31:0] branch_word,
   input  wire logic [31:0] fp_word,
   input  wire logic [31:0] jump_base_value,
   input  wire logic [31:0] source_s_value,
   input  wire logic [31:0] source_t_value,
   output result_type       result
);

   logic [5:0]  qual;
   class_type   cls;
   logic [5:0]  b_opc;
   logic [5:0]  b_fn;
   logic [4:0]  b_rd;
   logic [31:0] target;
   logic        lk_en;
   logic [4:0]  lk_idx;
   kind_type    kind;
   logic        operands_ok;
   verdict_type verdict;

   always_comb begin
      qual[4:0] = fp_status_word[16:12] & fp_status_word[11:7];
      qual[5]   = fp_status_word[17];
      if (qual[5])      cls = CLS_UNIMPL;
      else if (qual[4]) cls = CLS_INVALID;
      else if (qual[3]) cls = CLS_DIVZERO;
      else if (qual[2]) cls = CLS_OVERFLOW;
      else if (qual[1]) cls = CLS_UNDERFLOW;
      else if (qual[0]) cls = CLS_INEXACT;
      else              cls = CLS_NONE;
   end

   always_comb begin
      b_opc  = branch_word[31:26];
      b_fn   = branch_word[5:0];
      b_rd   = branch_word[15:11];
      target = '0;
      lk_en  = 1'b0;
      lk_idx = '0;
      if (b_opc == OPC_J || b_opc == OPC_JAL) begin
         target = {trap_pc[31:28], branch_word[25:0], 2'b00};
         if (b_opc == OPC_JAL) begin
            lk_en  = 1'b1;
            lk_idx = LINK_REG;
         end
      end else if (b_opc == OPC_SPECIAL && (b_fn == FN_JR || b_fn == FN_JALR)) begin
         target = jump_base_value;
         if (b_fn == FN_JALR && b_rd != 5'd0) begin
            lk_en  = 1'b1;
            lk_idx = b_rd;
         end
      end
   end

   always_comb begin
      kind        = op_kind(fp_word[25:21], fp_word[5:0]);
      operands_ok = float_ok(source_s_value);
      if (kind == KIND_THREE) operands_ok = operands_ok && float_ok(source_t_value);
      if (in_delay_slot && target == 32'd0)
         verdict = VERDICT_BAD_JUMP;
      else if (fp_word[31:26] != OPC_COP1)
         verdict = VERDICT_NOT_EMUL;
      else if (cls != CLS_UNDERFLOW && cls != CLS_UNIMPL)
         verdict = VERDICT_NO_SKIP;
      else if (kind == KIND_NONE)
         verdict = VERDICT_NOT_EMUL;
      else if (!operands_ok)
         verdict = VERDICT_NO_SKIP;
      else
         verdict = VERDICT_FIXED;
   end

   always_comb begin
      result.exc_class        = cls;
      result.verdict          = verdict;
      result.resume_pc        = in_delay_slot ? target : trap_pc + 32'd4;
      result.cleared_status   = {fp_status_word[31:18], 6'd0, fp_status_word[11:0]};
      result.zero_dest_enable = (verdict == VERDICT_FIXED);
      result.zero_dest_index  = (verdict == VERDICT_FIXED) ? fp_word[10:6] : 5'd0;
      result.link_enable      = in_delay_slot && lk_en;
      result.link_index       = (in_delay_slot && lk_en) ? lk_idx : 5'd0;
      result.link_value       = (in_delay_slot && lk_en) ? trap_pc + 32'd8 : 32'd0;
   end

endmodule
`default_nettype wire

// ----- rtl/ftfd_tally.sv -----
// Per-class exception counters with post-increment readout.
// Depends on ftfd_pkg.
`default_nettype none
module ftfd_tally
   import ftfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        bump,
   input  class_type        cls,
   output logic [31:0]      count
);

   logic [WordWidth-1:0] tally_ff [NumClasses];
   logic [WordWidth-1:0] count_in;

   always_comb begin
      case (cls)
         CLS_INEXACT, CLS_UNDERFLOW, CLS_OVERFLOW, CLS_DIVZERO,
         CLS_INVALID, CLS_UNIMPL, CLS_NONE:
            count_in = tally_ff[cls] + 32'd1;
         default: count_in = '0;
      endcase
   end

   assign count = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumClasses; i++) tally_ff[i] <= '0;
      end else if (bump && cls != 3'd7) begin
         tally_ff[cls] <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/fp_trap_fixup_decider.sv -----
// Top level: input register, trap decode and tally update, result register.
// Depends on ftfd_pkg, ftfd_decode and ftfd_tally.
// rsp_valid follows an accepted req through the input register, then the result register.
// One item per cycle unless rsp stalls; the decode and counter add sit between the registers.
// Back-pressure on rsp stalls both stages; req_ready stays high while a stage is free.
// Reset (synchronous, active high) empties both stages and clears all class tallies.
`default_nettype none
module fp_trap_fixup_decider
   import ftfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_fp_status_word,
   input  wire logic        req_in_delay_slot,
   input  wire logic [31:0] req_trap_pc,
   input  wire logic [31:0] req_branch_word,
   input  wire logic [31:0] req_fp_word,
   input  wire logic [31:0] req_jump_base_value,
   input  wire logic [31:0] req_source_s_value,
   input  wire logic [31:0] req_source_t_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_exception_class,
   output logic [1:0]       rsp_verdict,
   output logic [31:0]      rsp_resume_pc,
   output logic [31:0]      rsp_cleared_status,
   output logic             rsp_zero_dest_enable,
   output logic [4:0]       rsp_zero_dest_index,
   output logic             rsp_link_enable,
   output logic [4:0]       rsp_link_index,
   output logic [31:0]      rsp_link_value,
   output logic [31:0]      rsp_class_count
);

   logic        in_valid_ff;
   logic [31:0] status_ff, pc_ff, bword_ff, fword_ff, base_ff, vs_ff, vt_ff;
   logic        slot_ff;

   logic        out_valid_ff;
   result_type  result_ff;
   logic [31:0] count_ff;

   result_type  result_in;
   logic [31:0] count_in;
   logic        advance;
   logic        take;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else if (req_ready) in_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= req_fp_status_word;
         slot_ff   <= req_in_delay_slot;
         pc_ff     <= req_trap_pc;
         bword_ff  <= req_branch_word;
         fword_ff  <= req_fp_word;
         base_ff   <= req_jump_base_value;
         vs_ff     <= req_source_s_value;
         vt_ff     <= req_source_t_value;
      end
   end

   ftfd_decode u_decode (
      .fp_status_word  (status_ff),
      .in_delay_slot   (slot_ff),
      .trap_pc         (pc_ff),
      .branch_word     (bword_ff),
      .fp_word         (fword_ff),
      .jump_base_value (base_ff),
      .source_s_value  (vs_ff),
      .source_t_value  (vt_ff),
      .result          (result_in)
   );

   ftfd_tally u_tally (
      .clock (clock),
      .reset (reset),
      .bump  (in_valid_ff && advance),
      .cls   (result_in.exc_class),
      .count (count_in)
   );

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (advance) out_valid_ff <= in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         result_ff <= result_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_exception_class  = result_ff.exc_class;
   assign rsp_verdict          = result_ff.verdict;
   assign rsp_resume_pc        = result_ff.resume_pc;
   assign rsp_cleared_status   = result_ff.cleared_status;
   assign rsp_zero_dest_enable = result_ff.zero_dest_enable;
   assign rsp_zero_dest_index  = result_ff.zero_dest_index;
   assign rsp_link_enable      = result_ff.link_enable;
   assign rsp_link_index       = result_ff.link_index;
   assign rsp_link_value       = result_ff.link_value;
   assign rsp_class_count      = count_ff;

`ifndef NO_ASSERTIONS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(take && in_valid_ff && !advance))
      else $error("item accepted into a full input stage");

   a_fixed_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_FIXED |->
         (rsp_exception_class == CLS_UNDERFLOW || rsp_exception_class == CLS_UNIMPL))
      else $error("fixed verdict with a class that cannot be skipped");

   a_zero_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_zero_dest_enable == (rsp_verdict == VERDICT_FIXED)))
      else $error("destination write disagrees with verdict");

   a_link_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_link_enable |-> (rsp_link_index == 5'd0 && rsp_link_value == 32'd0))
      else $error("link fields set without a link write");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance |=> out_valid_ff)
      else $error("decoded item lost between stages");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_fp_trap_fixup_decider.sv -----
// Self-checking testbench for fp_trap_fixup_decider: a directed trap table, then random traps
// under several sender/receiver idling phases, checked against an in-bench fixup predictor.
// Depends on ftfd_pkg and the fp_trap_fixup_decider RTL.
`timescale 1ns / 100ps
module tb_fp_trap_fixup_decider;
   import ftfd_pkg::*;

   localparam logic [31:0] CAUSE_BITS      = 32'h0003_F000;
   localparam logic [31:0] ST_UNIMPL       = 32'h0002_0000;
   localparam logic [31:0] ST_UNDERFLOW    = 32'h0000_2100;
   localparam logic [31:0] ST_UNDER_MASKED = 32'h0000_2000;
   localparam logic [31:0] ST_OVERFLOW     = 32'h0000_4200;
   localparam logic [31:0] ST_INEXACT      = 32'h0000_1080;
   localparam logic [31:0] ST_DIVZERO      = 32'h0000_8400;
   localparam logic [31:0] ST_INVALID      = 32'h0001_0800;
   localparam logic [31:0] F_ONE           = 32'h3F80_0000;
   localparam logic [31:0] F_INF           = 32'h7F80_0000;
   localparam logic [31:0] F_DENORM        = 32'h0000_0001;
   localparam logic [5:0]  FN_ADD_S        = 6'd0;
   localparam logic [5:0]  FN_SUB_S        = 6'd1;
   localparam logic [5:0]  FN_MUL_S        = 6'd2;
   localparam logic [5:0]  FN_DIV_S        = 6'd3;
   localparam logic [5:0]  FN_SQRT_S       = 6'd4;
   localparam logic [5:0]  OPC_BEQ         = 6'd4;
   localparam int unsigned HOLD_CYCLES     = 60;
   localparam int unsigned PHASE_ITEMS     = 225;

   typedef struct packed {
      logic [31:0] fp_status_word;
      logic        in_delay_slot;
      logic [31:0] trap_pc;
      logic [31:0] branch_word;
      logic [31:0] fp_word;
      logic [31:0] jump_base_value;
      logic [31:0] source_s_value;
      logic [31:0] source_t_value;
   } trap_item_type;

   typedef struct packed {
      trap_item_type t;
      logic          pinned;
      class_type     cls;
      verdict_type   verdict;
   } trap_row_type;

   typedef struct packed {
      class_type   exc_class;
      verdict_type verdict;
      logic [31:0] resume_pc;
      logic [31:0] cleared_status;
      logic        zd_en;
      logic [4:0]  zd_idx;
      logic        lk_en;
      logic [4:0]  lk_idx;
      logic [31:0] lk_val;
      logic [31:0] class_count;
   } fixup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_fp_status_word = '0;
   logic        req_in_delay_slot = 1'b0;
   logic [31:0] req_trap_pc = '0;
   logic [31:0] req_branch_word = '0;
   logic [31:0] req_fp_word = '0;
   logic [31:0] req_jump_base_value = '0;
   logic [31:0] req_source_s_value = '0;
   logic [31:0] req_source_t_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_exception_class;
   logic [1:0]  rsp_verdict;
   logic [31:0] rsp_resume_pc;
   logic [31:0] rsp_cleared_status;
   logic        rsp_zero_dest_enable;
   logic [4:0]  rsp_zero_dest_index;
   logic        rsp_link_enable;
   logic [4:0]  rsp_link_index;
   logic [31:0] rsp_link_value;
   logic [31:0] rsp_class_count;

   logic        pin_valid = 1'b0;
   class_type   pin_cls = CLS_NONE;
   verdict_type pin_verdict = VERDICT_FIXED;

   logic [31:0]      class_tally [NumClasses];
   fixup_result_type pending_fixups [$];
   trap_row_type     directed_traps [$];
   int unsigned      mismatch_count = 0;
   int unsigned      idle_pct = 0;
   int unsigned      stall_pct = 0;
   int unsigned      burst_requests = 0;
   int unsigned      burst_served = 0;
   int unsigned      hold_left = 0;

   fp_trap_fixup_decider dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_fp_status_word   (req_fp_status_word),
      .req_in_delay_slot    (req_in_delay_slot),
      .req_trap_pc          (req_trap_pc),
      .req_branch_word      (req_branch_word),
      .req_fp_word          (req_fp_word),
      .req_jump_base_value  (req_jump_base_value),
      .req_source_s_value   (req_source_s_value),
      .req_source_t_value   (req_source_t_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_exception_class  (rsp_exception_class),
      .rsp_verdict          (rsp_verdict),
      .rsp_resume_pc        (rsp_resume_pc),
      .rsp_cleared_status   (rsp_cleared_status),
      .rsp_zero_dest_enable (rsp_zero_dest_enable),
      .rsp_zero_dest_index  (rsp_zero_dest_index),
      .rsp_link_enable      (rsp_link_enable),
      .rsp_link_index       (rsp_link_index),
      .rsp_link_value       (rsp_link_value),
      .rsp_class_count      (rsp_class_count)
   );

   always #10 clock = ~clock;

   function automatic logic is_ordinary_float(input logic [31:0] v);
      if (v[30:23] == 8'h00) return v[22:0] == 23'd0;
      return v[30:23] != 8'hFF;
   endfunction

   function automatic fixup_result_type predict_fixup(input trap_item_type t);
      fixup_result_type r;
      logic [5:0]  armed;
      logic [31:0] target;
      logic [5:0]  bop;
      logic [5:0]  bfn;
      logic [4:0]  fmt;
      logic [5:0]  ffn;
      int          operands;
      r = '0;
      armed = t.fp_status_word[17:12] & {1'b1, t.fp_status_word[11:7]};
      r.exc_class = CLS_NONE;
      for (int b = 0; b < 6; b++)
         if (armed[b]) r.exc_class = class_type'(b[2:0]);
      class_tally[r.exc_class] = class_tally[r.exc_class] + 32'd1;
      r.class_count = class_tally[r.exc_class];
      r.cleared_status = t.fp_status_word & ~CAUSE_BITS;
      r.resume_pc = t.trap_pc + 32'd4;
      r.verdict = VERDICT_FIXED;

      if (t.in_delay_slot) begin
         bop = t.branch_word[31:26];
         bfn = t.branch_word[5:0];
         target = '0;
         if (bop == OPC_J || bop == OPC_JAL) begin
            target = {t.trap_pc[31:28], t.branch_word[25:0], 2'b00};
            if (bop == OPC_JAL) begin
               r.lk_en = 1'b1;
               r.lk_idx = LINK_REG;
            end
         end else if (bop == OPC_SPECIAL && (bfn == FN_JR || bfn == FN_JALR)) begin
            if (bfn == FN_JALR && t.branch_word[15:11] != 5'd0) begin
               r.lk_en = 1'b1;
               r.lk_idx = t.branch_word[15:11];
            end
            target = t.jump_base_value;
         end
         if (r.lk_en) r.lk_val = t.trap_pc + 32'd8;
         r.resume_pc = target;
         if (target == 32'd0) r.verdict = VERDICT_BAD_JUMP;
      end

      if (r.verdict == VERDICT_FIXED) begin
         if (t.fp_word[31:26] != OPC_COP1) r.verdict = VERDICT_NOT_EMUL;
         else if (r.exc_class != CLS_UNDERFLOW && r.exc_class != CLS_UNIMPL)
            r.verdict = VERDICT_NO_SKIP;
      end

      if (r.verdict == VERDICT_FIXED) begin
         fmt = t.fp_word[25:21];
         ffn = t.fp_word[5:0];
         operands = 0;
         if (fmt == FMT_S && ffn <= FN_DIV_S) operands = 2;
         else if ((fmt == FMT_S && ffn == FN_ABS) || (fmt == FMT_D && ffn == FN_CVT_S) ||
                  (fmt == FMT_W && ffn == FN_CVT_S) || (fmt == FMT_S && ffn == FN_CVT_W))
            operands = 1;
         if (operands == 0) begin
            r.verdict = VERDICT_NOT_EMUL;
         end else if (is_ordinary_float(t.source_s_value) &&
                      (operands == 1 || is_ordinary_float(t.source_t_value))) begin
            r.zd_en = 1'b1;
            r.zd_idx = t.fp_word[10:6];
         end else begin
            r.verdict = VERDICT_NO_SKIP;
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic logic [31:0] cop1_word(input logic [4:0] fmt, input logic [5:0] fn,
                                             input logic [4:0] fd);
      return {OPC_COP1, fmt, 5'd2, 5'd4, fd, fn};
   endfunction

   function automatic trap_row_type trap_row(
      input logic [31:0] sw, input logic slot, input logic [31:0] pc,
      input logic [31:0] bw, input logic [31:0] fw, input logic [31:0] base,
      input logic [31:0] vs, input logic [31:0] vt,
      input class_type cls, input verdict_type verdict);
      trap_row_type r;
      r.t = '{sw, slot, pc, bw, fw, base, vs, vt};
      r.pinned = 1'b1;
      r.cls = cls;
      r.verdict = verdict;
      return r;
   endfunction

   function automatic logic [31:0] shape_float(input logic [31:0] raw);
      logic [31:0] v;
      v = raw;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: v[30:23] = 8'($urandom_range(254, 1));
         6: v[30:0] = '0;
         7: v[30:23] = 8'hFF;
         8: v[30:23] = 8'h00;
         default: ;
      endcase
      return v;
   endfunction

   function automatic trap_row_type random_row();
      trap_row_type r;
      int unsigned  pick;
      r.pinned = 1'b0;
      r.cls = CLS_NONE;
      r.verdict = VERDICT_FIXED;
      r.t.fp_status_word = $urandom();
      pick = $urandom_range(99);
      if (pick < 45) begin
         r.t.fp_status_word[17] = 1'b1;
      end else if (pick < 75) begin
         r.t.fp_status_word[17] = 1'b0;
         r.t.fp_status_word[13] = 1'b1;
         r.t.fp_status_word[8] = 1'b1;
         r.t.fp_status_word[11:9] = 3'b000;
      end
      r.t.in_delay_slot = ($urandom_range(99) < 35);
      r.t.trap_pc = $urandom();
      r.t.branch_word = $urandom();
      pick = $urandom_range(99);
      if (pick < 25) begin
         r.t.branch_word[31:26] = OPC_J;
      end else if (pick < 50) begin
         r.t.branch_word[31:26] = OPC_JAL;
      end else if (pick < 85) begin
         r.t.branch_word[31:26] = OPC_SPECIAL;
         r.t.branch_word[5:0] = $urandom_range(1) ? FN_JALR : FN_JR;
         if ($urandom_range(3) == 0) r.t.branch_word[15:11] = 5'd0;
      end
      r.t.jump_base_value = ($urandom_range(19) == 0) ? 32'd0 : $urandom();
      r.t.fp_word = $urandom();
      pick = $urandom_range(99);
      if (pick < 90) r.t.fp_word[31:26] = OPC_COP1;
      if (pick < 75) begin
         case ($urandom_range(7))
            0, 1, 2, 3: begin
               r.t.fp_word[25:21] = FMT_S;
               r.t.fp_word[5:0] = 6'($urandom_range(FN_DIV_S));
            end
            4: begin
               r.t.fp_word[25:21] = FMT_S;
               r.t.fp_word[5:0] = FN_ABS;
            end
            5: begin
               r.t.fp_word[25:21] = FMT_D;
               r.t.fp_word[5:0] = FN_CVT_S;
            end
            6: begin
               r.t.fp_word[25:21] = FMT_W;
               r.t.fp_word[5:0] = FN_CVT_S;
            end
            default: begin
               r.t.fp_word[25:21] = FMT_S;
               r.t.fp_word[5:0] = FN_CVT_W;
            end
         endcase
      end
      r.t.source_s_value = shape_float($urandom());
      r.t.source_t_value = shape_float($urandom());
      return r;
   endfunction

   task automatic offer_trap(input trap_row_type row);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid           <= 1'b1;
      req_fp_status_word  <= row.t.fp_status_word;
      req_in_delay_slot   <= row.t.in_delay_slot;
      req_trap_pc         <= row.t.trap_pc;
      req_branch_word     <= row.t.branch_word;
      req_fp_word         <= row.t.fp_word;
      req_jump_base_value <= row.t.jump_base_value;
      req_source_s_value  <= row.t.source_s_value;
      req_source_t_value  <= row.t.source_t_value;
      pin_valid           <= row.pinned;
      pin_cls             <= row.cls;
      pin_verdict         <= row.verdict;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (burst_served != burst_requests) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES - 1;
         burst_served <= burst_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : scoreboard
      fixup_result_type want;
      trap_item_type    seen;
      if (reset) begin
         foreach (class_tally[i]) class_tally[i] = '0;
      end else begin
         if (req_valid && req_ready) begin
            seen = '{req_fp_status_word, req_in_delay_slot, req_trap_pc, req_branch_word,
                     req_fp_word, req_jump_base_value, req_source_s_value, req_source_t_value};
            want = predict_fixup(seen);
            if (pin_valid) begin
               want.exc_class = pin_cls;
               want.verdict = pin_verdict;
            end
            pending_fixups.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_fixups.size() == 0) begin
               $error("result item with no expected fixup pending");
               mismatch_count++;
            end else begin
               want = pending_fixups.pop_front();
               check_field("exception_class", 32'(want.exc_class), 32'(rsp_exception_class));
               check_field("verdict", 32'(want.verdict), 32'(rsp_verdict));
               check_field("resume_pc", want.resume_pc, rsp_resume_pc);
               check_field("cleared_status", want.cleared_status, rsp_cleared_status);
               check_field("zero_dest_enable", 32'(want.zd_en), 32'(rsp_zero_dest_enable));
               check_field("zero_dest_index", 32'(want.zd_idx), 32'(rsp_zero_dest_index));
               check_field("link_enable", 32'(want.lk_en), 32'(rsp_link_enable));
               check_field("link_index", 32'(want.lk_idx), 32'(rsp_link_index));
               check_field("link_value", want.lk_val, rsp_link_value);
               check_field("class_count", want.class_count, rsp_class_count);
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned idle_by_phase [4];
      int unsigned stall_by_phase [4];
      idle_by_phase = '{0, 51, 0, 37};
      stall_by_phase = '{0, 0, 51, 37};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_traps.push_back(trap_row('0, 1'b0, '0, '0, '0, '0, '0, '0,
                                        CLS_NONE, VERDICT_NOT_EMUL));
      directed_traps.push_back(trap_row(32'hFFFF_FFFF, 1'b0, 32'h0040_0000, '0,
                                        cop1_word(FMT_S, FN_ADD_S, 5'd1), '0, F_ONE, F_ONE,
                                        CLS_UNIMPL, VERDICT_FIXED));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b0, 32'h0040_0100, '0,
                                        cop1_word(FMT_S, FN_SUB_S, 5'd0), '0, '0, F_ONE,
                                        CLS_UNIMPL, VERDICT_FIXED));
      directed_traps.push_back(trap_row(ST_UNDERFLOW, 1'b0, 32'h0040_0200, '0,
                                        cop1_word(FMT_S, FN_MUL_S, 5'd31), '0, F_ONE, F_ONE,
                                        CLS_UNDERFLOW, VERDICT_FIXED));
      directed_traps.push_back(trap_row(ST_UNDER_MASKED, 1'b0, 32'h0040_0300, '0,
                                        cop1_word(FMT_S, FN_MUL_S, 5'd3), '0, F_ONE, F_ONE,
                                        CLS_NONE, VERDICT_NO_SKIP));
      directed_traps.push_back(trap_row(ST_OVERFLOW, 1'b0, 32'h0040_0400, '0,
                                        cop1_word(FMT_S, FN_ADD_S, 5'd3), '0, F_ONE, F_ONE,
                                        CLS_OVERFLOW, VERDICT_NO_SKIP));
      directed_traps.push_back(trap_row(ST_INEXACT, 1'b0, 32'h0040_0500, '0,
                                        cop1_word(FMT_S, FN_ADD_S, 5'd3), '0, F_ONE, F_ONE,
                                        CLS_INEXACT, VERDICT_NO_SKIP));
      directed_traps.push_back(trap_row(ST_DIVZERO, 1'b0, 32'h0040_0600, '0,
                                        cop1_word(FMT_S, FN_DIV_S, 5'd3), '0, F_ONE, '0,
                                        CLS_DIVZERO, VERDICT_NO_SKIP));
      directed_traps.push_back(trap_row(ST_INVALID, 1'b0, 32'h0040_0700, '0,
                                        cop1_word(FMT_S, FN_DIV_S, 5'd3), '0, '0, '0,
                                        CLS_INVALID, VERDICT_NO_SKIP));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b0, 32'h0040_0800, '0,
                                        cop1_word(FMT_S, FN_ABS, 5'd7), '0, 32'hBF80_0000, F_INF,
                                        CLS_UNIMPL, VERDICT_FIXED));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b0, 32'h0040_0900, '0,
                                        cop1_word(FMT_D, FN_CVT_S, 5'd8), '0, '0, F_INF,
                                        CLS_UNIMPL, VERDICT_FIXED));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b0, 32'h0040_0A00, '0,
                                        cop1_word(FMT_W, FN_CVT_S, 5'd9), '0, 32'h7F7F_FFFF,
                                        F_DENORM, CLS_UNIMPL, VERDICT_FIXED));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b0, 32'h0040_0B00, '0,
                                        cop1_word(FMT_S, FN_CVT_W, 5'd10), '0, 32'h0080_0000,
                                        32'hFFFF_FFFF, CLS_UNIMPL, VERDICT_FIXED));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b0, 32'h0040_0C00, '0,
                                        cop1_word(FMT_S, FN_DIV_S, 5'd11), '0, F_ONE, F_INF,
                                        CLS_UNIMPL, VERDICT_NO_SKIP));
      directed_traps.push_back(trap_row(ST_UNDERFLOW, 1'b0, 32'h0040_0D00, '0,
                                        cop1_word(FMT_S, FN_SUB_S, 5'd12), '0, F_DENORM, F_ONE,
                                        CLS_UNDERFLOW, VERDICT_NO_SKIP));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b0, 32'h0040_0E00, '0,
                                        cop1_word(FMT_S, FN_SQRT_S, 5'd13), '0, F_ONE, F_ONE,
                                        CLS_UNIMPL, VERDICT_NOT_EMUL));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b0, 32'h0040_0F00, '0,
                                        cop1_word(FMT_D, FN_ADD_S, 5'd14), '0, F_ONE, F_ONE,
                                        CLS_UNIMPL, VERDICT_NOT_EMUL));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b1, 32'hA000_0010,
                                        {OPC_J, 26'h3FF_FFFF},
                                        cop1_word(FMT_S, FN_ADD_S, 5'd15), '0, F_ONE, F_ONE,
                                        CLS_UNIMPL, VERDICT_FIXED));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b1, 32'h0000_1000, {OPC_JAL, 26'd0},
                                        cop1_word(FMT_S, FN_ADD_S, 5'd16), '0, F_ONE, F_ONE,
                                        CLS_UNIMPL, VERDICT_BAD_JUMP));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b1, 32'h0000_2000,
                                        {OPC_SPECIAL, 5'd4, 5'd0, 5'd0, 5'd0, FN_JR},
                                        cop1_word(FMT_S, FN_MUL_S, 5'd17), 32'h8000_0000,
                                        F_ONE, F_ONE, CLS_UNIMPL, VERDICT_FIXED));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b1, 32'h0000_3000,
                                        {OPC_SPECIAL, 5'd4, 5'd0, 5'd0, 5'd0, FN_JALR},
                                        cop1_word(FMT_S, FN_MUL_S, 5'd18), '0, F_ONE, F_ONE,
                                        CLS_UNIMPL, VERDICT_BAD_JUMP));
      directed_traps.push_back(trap_row(ST_UNDERFLOW, 1'b1, 32'h0000_4000,
                                        {OPC_SPECIAL, 5'd4, 5'd0, 5'd5, 5'd0, FN_JALR},
                                        cop1_word(FMT_S, FN_ABS, 5'd19), 32'hFFFF_FFFC,
                                        F_ONE, F_ONE, CLS_UNDERFLOW, VERDICT_FIXED));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b1, 32'h0000_5000, {OPC_BEQ, 26'h123},
                                        cop1_word(FMT_S, FN_ADD_S, 5'd20), 32'h1234_5678,
                                        F_ONE, F_ONE, CLS_UNIMPL, VERDICT_BAD_JUMP));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b0, 32'hFFFF_FFFC, '0,
                                        cop1_word(FMT_S, FN_ADD_S, 5'd21), '0, F_ONE, F_ONE,
                                        CLS_UNIMPL, VERDICT_FIXED));
      directed_traps.push_back(trap_row(ST_UNIMPL, 1'b1, 32'h5000_0000,
                                        {OPC_JAL, 26'h123_4567}, '0, '0, F_ONE, F_ONE,
                                        CLS_UNIMPL, VERDICT_NOT_EMUL));

      foreach (directed_traps[i]) offer_trap(directed_traps[i]);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = idle_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         if (phase < 2) burst_requests++;
         repeat (PHASE_ITEMS) offer_trap(random_row());
      end
      req_valid <= 1'b0;

      while (pending_fixups.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) $display("PASS fp_trap_fixup_decider");
      else $display("FAIL fp_trap_fixup_decider");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAIL fp_trap_fixup_decider");
      $finish;
   end

endmodule
